// ===== rtl/shlg_pkg.sv =====
// Shared types and constants for the SVR loss/gradient engine.
// No dependencies.
package shlg_pkg;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_FEAT   = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;
	localparam logic [1:0] ACT_RSVD   = 2'd3;

	localparam logic [1:0] REG_LAMBDA = 2'd0;
	localparam logic [1:0] REG_MARGIN = 2'd1;
	localparam logic [1:0] REG_DIMS   = 2'd2;

	localparam logic [46:0] LOSS_MAX = {47{1'b1}};

	typedef struct packed {
		logic [1:0]         action;
		logic [4:0]         element_index;
		logic signed [31:0] value;
		logic signed [31:0] target;
		logic               last_element;
	} in_word_t;

	typedef struct packed {
		logic [46:0]        loss;
		logic [4:0]         grad_index;
		logic signed [31:0] grad_value;
		logic               last_of_run;
	} out_word_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FEAT_RD, ST_FEAT_MUL, ST_FEAT_ACC,
		ST_CL_RES, ST_CL_MAG, ST_CL_CMP, ST_CL_LOSS,
		ST_W_BUF, ST_W_GRD, ST_W_WR, ST_CL_END,
		ST_SQ_RD, ST_SQ_MUL, ST_SQ_ACC,
		ST_RG_LO, ST_RG_HI, ST_RG_SUM, ST_RG_TOT,
		ST_GR_RD, ST_GR_MUL, ST_GR_OUT, ST_FIN_END
	} shlg_state_t;

	typedef enum logic [4:0] {
		OP_IDLE, OP_FEAT_RD, OP_FEAT_MUL, OP_FEAT_ACC,
		OP_CL_RES, OP_CL_MAG, OP_CL_CMP, OP_CL_LOSS,
		OP_W_BUF, OP_W_GRD, OP_W_WR, OP_CL_END,
		OP_SQ_RD, OP_SQ_MUL, OP_SQ_ACC,
		OP_RG_LO, OP_RG_HI, OP_RG_SUM, OP_RG_TOT,
		OP_GR_RD, OP_GR_MUL, OP_GR_OUT, OP_FIN_END
	} dp_op_t;

	typedef struct packed {
		logic   accept;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic last_elem;
		logic walk_go;
		logic walk_more;
		logic i_more;
	} dp_stat_t;

endpackage

// ===== rtl/svr_hinge_loss_gradient.sv =====
// Top level of the SVR loss/gradient engine: APB register file, sequencer
// and datapath. Depends on shlg_pkg, shlg_ctrl, shlg_dp.
//
// A word is taken when start is high and busy is low. A weight load takes
// effect at once and leaves busy low. A feature word passes read, multiply
// and accumulate states; the word closing a sample adds residual, magnitude,
// compare, loss and end states, and per buffered feature a read-modify-write
// of the gradient memory when the margin is exceeded. Finish forms the weight
// norm, then gives m results, then clears. Results appear on res for a
// single cycle marked by res_stb and cannot be stalled.
module svr_hinge_loss_gradient #(
	parameter int MAX_DIMS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  shlg_pkg::in_word_t  item,
	output logic                res_stb,
	output shlg_pkg::out_word_t res,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import shlg_pkg::*;

	logic [31:0] lambda_q;
	logic [30:0] margin_q;
	logic [5:0]  dims_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= 32'd65536;
			margin_q <= '0;
			dims_q   <= 6'd32;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_LAMBDA: lambda_q <= pwdata;
				REG_MARGIN: margin_q <= pwdata[30:0];
				REG_DIMS:   dims_q   <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LAMBDA: prdata = lambda_q;
			REG_MARGIN: prdata = {1'b0, margin_q};
			REG_DIMS:   prdata = {26'd0, dims_q};
			default:    prdata = '0;
		endcase
	end

	shlg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	shlg_dp #(.MAX_DIMS(MAX_DIMS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.item    (item),
		.lambda  (lambda_q),
		.margin  (margin_q),
		.dims    (dims_q),
		.stat    (stat),
		.res_stb (res_stb),
		.res     (res)
	);

endmodule

// ===== rtl/shlg_ctrl.sv =====
// Sequencer for the SVR loss/gradient engine.
// Depends on shlg_pkg; drives shlg_dp through command/status structs.
module shlg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         action,
	input  shlg_pkg::dp_stat_t stat,
	output shlg_pkg::dp_cmd_t  cmd,
	output logic               busy
);
	import shlg_pkg::*;

	shlg_state_t state_q, state_d;
	logic        accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_FEAT) state_d = ST_FEAT_RD;
				else if (accept && action == ACT_FINISH) state_d = ST_SQ_RD;
			end
			ST_FEAT_RD:  state_d = ST_FEAT_MUL;
			ST_FEAT_MUL: state_d = ST_FEAT_ACC;
			ST_FEAT_ACC: state_d = stat.last_elem ? ST_CL_RES : ST_IDLE;
			ST_CL_RES:   state_d = ST_CL_MAG;
			ST_CL_MAG:   state_d = ST_CL_CMP;
			ST_CL_CMP:   state_d = ST_CL_LOSS;
			ST_CL_LOSS:  state_d = stat.walk_go ? ST_W_BUF : ST_CL_END;
			ST_W_BUF:    state_d = ST_W_GRD;
			ST_W_GRD:    state_d = ST_W_WR;
			ST_W_WR:     state_d = stat.walk_more ? ST_W_BUF : ST_CL_END;
			ST_CL_END:   state_d = ST_IDLE;
			ST_SQ_RD:    state_d = ST_SQ_MUL;
			ST_SQ_MUL:   state_d = ST_SQ_ACC;
			ST_SQ_ACC:   state_d = stat.i_more ? ST_SQ_RD : ST_RG_LO;
			ST_RG_LO:    state_d = ST_RG_HI;
			ST_RG_HI:    state_d = ST_RG_SUM;
			ST_RG_SUM:   state_d = ST_RG_TOT;
			ST_RG_TOT:   state_d = ST_GR_RD;
			ST_GR_RD:    state_d = ST_GR_MUL;
			ST_GR_MUL:   state_d = ST_GR_OUT;
			ST_GR_OUT:   state_d = stat.i_more ? ST_GR_RD : ST_FIN_END;
			ST_FIN_END:  state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.accept = accept;
		busy       = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:     cmd.op = OP_IDLE;
			ST_FEAT_RD:  cmd.op = OP_FEAT_RD;
			ST_FEAT_MUL: cmd.op = OP_FEAT_MUL;
			ST_FEAT_ACC: cmd.op = OP_FEAT_ACC;
			ST_CL_RES:   cmd.op = OP_CL_RES;
			ST_CL_MAG:   cmd.op = OP_CL_MAG;
			ST_CL_CMP:   cmd.op = OP_CL_CMP;
			ST_CL_LOSS:  cmd.op = OP_CL_LOSS;
			ST_W_BUF:    cmd.op = OP_W_BUF;
			ST_W_GRD:    cmd.op = OP_W_GRD;
			ST_W_WR:     cmd.op = OP_W_WR;
			ST_CL_END:   cmd.op = OP_CL_END;
			ST_SQ_RD:    cmd.op = OP_SQ_RD;
			ST_SQ_MUL:   cmd.op = OP_SQ_MUL;
			ST_SQ_ACC:   cmd.op = OP_SQ_ACC;
			ST_RG_LO:    cmd.op = OP_RG_LO;
			ST_RG_HI:    cmd.op = OP_RG_HI;
			ST_RG_SUM:   cmd.op = OP_RG_SUM;
			ST_RG_TOT:   cmd.op = OP_RG_TOT;
			ST_GR_RD:    cmd.op = OP_GR_RD;
			ST_GR_MUL:   cmd.op = OP_GR_MUL;
			ST_GR_OUT:   cmd.op = OP_GR_OUT;
			ST_FIN_END:  cmd.op = OP_FIN_END;
			default:     cmd.op = OP_IDLE;
		endcase
	end

endmodule

// ===== rtl/shlg_dp.sv =====
// Datapath for the SVR loss/gradient engine: weight, gradient and sample
// memories, accumulators and arithmetic. Depends on shlg_pkg.
module shlg_dp #(
	parameter int MAX_DIMS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  shlg_pkg::dp_cmd_t  cmd,
	input  shlg_pkg::in_word_t item,
	input  logic [31:0]        lambda,
	input  logic [30:0]        margin,
	input  logic [5:0]         dims,
	output shlg_pkg::dp_stat_t stat,
	output logic               res_stb,
	output shlg_pkg::out_word_t res
);
	import shlg_pkg::*;

	localparam int AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int FW  = $clog2(MAX_DIMS + 1);
	localparam int CAP = (MAX_DIMS < 32) ? MAX_DIMS : 32;

	logic signed [31:0] w_mem [MAX_DIMS];
	logic signed [47:0] g_mem [MAX_DIMS];
	logic [36:0]        b_mem [MAX_DIMS];
	logic [MAX_DIMS-1:0] w_vld_q, g_vld_q;

	in_word_t           in_q;
	logic [5:0]         m;
	logic [FW-1:0]      fill_q, k_q;
	logic [5:0]         i_q;
	logic signed [63:0] dot_q, r_q;
	logic [46:0]        loss_q, reg_q, total_q;
	logic               elig_q, hit_q, neg_q;
	logic [63:0]        mag_q, prod_q;
	logic [47:0]        exc_q;
	logic signed [31:0] w_rd_s1;
	logic signed [47:0] g_rd_s1;
	logic [36:0]        b_rd_s1;
	logic [51:0]        s_q;
	logic [63:0]        pl_q;
	logic [51:0]        ph_q;
	logic [AW-1:0]      w_addr, g_addr;
	logic               res_stb_q;
	out_word_t          res_q;

	logic signed [64:0] dsum, rdiff;
	logic [31:0]        absw;
	logic [83:0]        full;
	logic [47:0]        lsum_c, lsum_t;
	logic signed [31:0] bval;
	logic signed [48:0] gsum;
	logic signed [48:0] term;
	logic signed [49:0] gout;
	logic signed [31:0] gclamp;
	logic               feat_ok;

	always_comb begin
		if (dims == 6'd0) m = 6'd1;
		else if (dims > 6'(CAP)) m = 6'(CAP);
		else m = dims;
	end

	assign feat_ok = ({1'b0, in_q.element_index} < m) && (fill_q < FW'(MAX_DIMS));
	assign absw    = w_rd_s1[31] ? 32'(-w_rd_s1) : w_rd_s1;

	assign dsum  = {dot_q[63], dot_q} + {prod_q[63], prod_q};
	assign rdiff = {dot_q[63], dot_q}
		- {{17{in_q.target[31]}}, in_q.target, 16'd0};
	assign full  = {ph_q, 32'd0} + {20'd0, pl_q};
	assign lsum_c = {1'b0, loss_q} + {1'b0, exc_q[46:0]};
	assign lsum_t = {1'b0, loss_q} + {1'b0, reg_q};

	assign bval = b_rd_s1[31:0];
	assign gsum = {g_rd_s1[47], g_rd_s1} + (neg_q ? -49'(bval) : 49'(bval));
	assign term = neg_q ? -{1'b0, prod_q[63:16]} : {1'b0, prod_q[63:16]};
	assign gout = {{2{g_rd_s1[47]}}, g_rd_s1} + {term[48], term};

	always_comb begin
		if (gout[49:31] == {19{gout[49]}}) gclamp = gout[31:0];
		else if (gout[49]) gclamp = 32'sh8000_0000;
		else gclamp = 32'sh7FFF_FFFF;
	end

	always_comb begin
		w_addr = AW'(i_q);
		g_addr = AW'(i_q);
		if (cmd.op == OP_FEAT_RD) w_addr = AW'(in_q.element_index);
		if (cmd.op == OP_W_GRD) g_addr = AW'(b_rd_s1[36:32]);
	end

	// weight memory
	always_ff @(posedge clk) begin
		if (cmd.accept && item.action == ACT_LOAD && 32'(item.element_index) < MAX_DIMS)
			w_mem[AW'(item.element_index)] <= item.value;
		w_rd_s1 <= w_vld_q[w_addr] ? w_mem[w_addr] : 32'sd0;
	end

	// gradient memory
	always_ff @(posedge clk) begin
		if (cmd.op == OP_W_WR)
			g_mem[AW'(b_rd_s1[36:32])] <= (gsum[48] != gsum[47])
				? {gsum[48], {47{~gsum[48]}}} : gsum[47:0];
		g_rd_s1 <= g_vld_q[g_addr] ? g_mem[g_addr] : 48'sd0;
	end

	// sample buffer
	always_ff @(posedge clk) begin
		if (cmd.op == OP_FEAT_RD && feat_ok)
			b_mem[fill_q[AW-1:0]] <= {in_q.element_index, in_q.value};
		b_rd_s1 <= b_mem[k_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_vld_q   <= '0;
			g_vld_q   <= '0;
			fill_q    <= '0;
			dot_q     <= '0;
			loss_q    <= '0;
			res_stb_q <= 1'b0;
		end else begin
			res_stb_q <= (cmd.op == OP_GR_OUT);
			if (cmd.accept && item.action == ACT_LOAD && 32'(item.element_index) < MAX_DIMS)
				w_vld_q[AW'(item.element_index)] <= 1'b1;
			case (cmd.op)
				OP_FEAT_RD: if (feat_ok) fill_q <= fill_q + 1'b1;
				OP_FEAT_ACC: begin
					if (elig_q)
						dot_q <= (dsum[64] != dsum[63])
							? {dsum[64], {63{~dsum[64]}}} : dsum[63:0];
				end
				OP_CL_LOSS: begin
					if (hit_q)
						loss_q <= (exc_q[47] || lsum_c[47]) ? LOSS_MAX : lsum_c[46:0];
				end
				OP_W_WR: g_vld_q[AW'(b_rd_s1[36:32])] <= 1'b1;
				OP_CL_END: begin
					dot_q  <= '0;
					fill_q <= '0;
				end
				OP_FIN_END: begin
					g_vld_q <= '0;
					loss_q  <= '0;
					dot_q   <= '0;
					fill_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q <= item;
			i_q  <= '0;
			s_q  <= '0;
		end
		case (cmd.op)
			OP_FEAT_RD:  elig_q <= feat_ok;
			OP_FEAT_MUL: prod_q <= 64'(w_rd_s1 * in_q.value);
			OP_CL_RES:
				r_q <= (rdiff[64] != rdiff[63])
					? {rdiff[64], {63{~rdiff[64]}}} : rdiff[63:0];
			OP_CL_MAG: begin
				mag_q <= r_q[63] ? 64'(-r_q) : r_q;
				neg_q <= r_q[63];
			end
			OP_CL_CMP: begin
				hit_q <= mag_q > {17'd0, margin, 16'd0};
				exc_q <= 48'((mag_q - {17'd0, margin, 16'd0}) >> 16);
			end
			OP_CL_LOSS: k_q <= '0;
			OP_W_WR:    k_q <= k_q + 1'b1;
			OP_SQ_MUL:  prod_q <= absw * absw;
			OP_SQ_ACC: begin
				s_q <= s_q + {4'd0, prod_q[63:16]};
				i_q <= i_q + 1'b1;
			end
			OP_RG_LO:  pl_q <= lambda * s_q[31:0];
			OP_RG_HI:  ph_q <= lambda * s_q[51:32];
			OP_RG_SUM: reg_q <= (full[83:64] != 20'd0) ? LOSS_MAX : full[63:17];
			OP_RG_TOT: begin
				total_q <= lsum_t[47] ? LOSS_MAX : lsum_t[46:0];
				i_q     <= '0;
			end
			OP_GR_MUL: begin
				prod_q <= lambda * absw;
				neg_q  <= w_rd_s1[31];
			end
			OP_GR_OUT: begin
				res_q.loss        <= total_q;
				res_q.grad_index  <= i_q[4:0];
				res_q.grad_value  <= gclamp;
				res_q.last_of_run <= !stat.i_more;
				i_q               <= i_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign stat.last_elem = in_q.last_element;
	assign stat.walk_go   = hit_q && (fill_q != '0);
	assign stat.walk_more = (k_q + 1'b1) < fill_q;
	assign stat.i_more    = (i_q + 6'd1) != m;
	assign res_stb        = res_stb_q;
	assign res            = res_q;

endmodule

// ===== tb/sv/svr_hinge_loss_gradient_test.sv =====
// Self-checking testbench for svr_hinge_loss_gradient: a directed table, then random
// samples and finishes under several register settings, checked against a local predictor.
// Depends on shlg_pkg and the svr_hinge_loss_gradient RTL.
`timescale 1ns / 100ps
module svr_hinge_loss_gradient_test;
	import shlg_pkg::*;

	localparam int NDIM = 32;
	localparam longint S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
	localparam longint S64_MIN = 64'sh8000000000000000;
	localparam longint G48_MAX = 64'sh00007FFFFFFFFFFF;
	localparam longint G48_MIN = -G48_MAX - 1;
	localparam longint I32_MAX = 64'sh000000007FFFFFFF;
	localparam longint I32_MIN = -I32_MAX - 1;
	localparam logic [63:0] LMAX = {17'd0, LOSS_MAX};
	localparam int LIMIT = 400000;

	logic clk = 1'b0, arst_n = 1'b0, start = 1'b0;
	logic busy, res_stb, pready;
	in_word_t item = '0;
	out_word_t res;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;

	svr_hinge_loss_gradient dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] lam;
	logic [30:0] marg;
	logic [5:0] dims;
	longint wts[NDIM], gsum[NDIM], bval[NDIM];
	int unsigned bidx[NDIM];
	logic [63:0] lsum;
	longint dot;
	int fill;

	out_word_t grad_q[$];
	int errors = 0, words_sent = 0, results_seen = 0, finishes = 0, idle_pct = 0;
	int cycles = 0;

	function automatic int eff_dims();
		if (dims < 1) return 1;
		if (dims > NDIM) return NDIM;
		return int'(dims);
	endfunction

	function automatic longint sat64(logic signed [64:0] v);
		if (v > $signed({1'b0, S64_MAX})) return S64_MAX;
		if (v < $signed({1'b1, S64_MIN})) return S64_MIN;
		return v[63:0];
	endfunction

	function automatic longint clampv(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [63:0] loss_add(logic [63:0] a, logic [63:0] b);
		if (b > LMAX || a > LMAX - b) return LMAX;
		return a + b;
	endfunction

	function automatic void close_sample(longint tgt);
		longint r, d;
		logic [63:0] mag, thr;
		r = sat64($signed({dot[63], dot}) - $signed({tgt[63], tgt * 65536}));
		mag = r < 0 ? 64'd0 - r : r;
		thr = {17'd0, marg, 16'd0};
		if (mag > thr) begin
			lsum = loss_add(lsum, (mag - thr) >> 16);
			for (int k = 0; k < fill; k++) begin
				d = r < 0 ? -bval[k] : bval[k];
				gsum[bidx[k]] = clampv(gsum[bidx[k]] + d, G48_MIN, G48_MAX);
			end
		end
		dot = 0;
		fill = 0;
	endfunction

	function automatic void finish_run(ref out_word_t q[$]);
		int m;
		logic [63:0] s, w, rg, total, mg;
		logic [127:0] prod;
		longint qv;
		out_word_t o;
		m = eff_dims();
		s = 0;
		for (int i = 0; i < m; i++) begin
			w = wts[i] < 0 ? -wts[i] : wts[i];
			s += (w * w) >> 16;
		end
		prod = {96'd0, lam} * {64'd0, s};
		rg = prod[127:64] != 0 ? LMAX : prod[63:0] >> 17;
		total = loss_add(lsum, rg);
		for (int i = 0; i < m; i++) begin
			w = wts[i] < 0 ? -wts[i] : wts[i];
			mg = {32'd0, lam} * w;
			qv = mg >> 16;
			o.loss = total[46:0];
			o.grad_index = 5'(i);
			o.grad_value = 32'(clampv(gsum[i] + (wts[i] < 0 ? -qv : qv), I32_MIN, I32_MAX));
			o.last_of_run = (i == m - 1);
			q.push_back(o);
		end
		for (int i = 0; i < NDIM; i++) gsum[i] = 0;
		lsum = 0;
		dot = 0;
		fill = 0;
	endfunction

	function automatic void predict_word(in_word_t x, ref out_word_t q[$]);
		case (x.action)
			ACT_LOAD: wts[x.element_index] = x.value;
			ACT_FEAT: begin
				if (x.element_index < eff_dims() && fill < NDIM) begin
					dot = sat64($signed({dot[63], dot}) + (wts[x.element_index] * longint'(x.value)));
					bidx[fill] = x.element_index;
					bval[fill] = x.value;
					fill++;
				end
				if (x.last_element) close_sample(x.target);
			end
			ACT_FINISH: finish_run(q);
			default: ;
		endcase
	endfunction

	function automatic void reset_model();
		lam = 32'd65536;
		marg = '0;
		dims = 6'd32;
		for (int i = 0; i < NDIM; i++) begin
			wts[i] = 0;
			gsum[i] = 0;
		end
		lsum = 0;
		dot = 0;
		fill = 0;
	endfunction

	// result checker
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (res_stb) begin
			results_seen <= results_seen + 1;
			if (grad_q.size() == 0) begin
				$error("unexpected result word idx=%0d", res.grad_index);
				errors++;
			end else begin
				out_word_t e;
				e = grad_q.pop_front();
				if (res.loss !== e.loss) begin
					$error("loss exp %0d got %0d", e.loss, res.loss);
					errors++;
				end
				if (res.grad_index !== e.grad_index) begin
					$error("grad_index exp %0d got %0d", e.grad_index, res.grad_index);
					errors++;
				end
				if (res.grad_value !== e.grad_value) begin
					$error("grad_value exp %0d got %0d", e.grad_value, res.grad_value);
					errors++;
				end
				if (res.last_of_run !== e.last_of_run) begin
					$error("last_of_run exp %0b got %0b", e.last_of_run, res.last_of_run);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("svr_hinge_loss_gradient regression: fail");
			$finish;
		end
	end

	task automatic send(in_word_t x, bit typed_zero = 0);
		out_word_t tmp[$];
		if ($urandom_range(99) < idle_pct)
			repeat ($urandom_range(1, 4)) @(negedge clk) start <= 1'b0;
		@(negedge clk);
		start <= 1'b1;
		item <= x;
		do @(posedge clk); while (busy);
		words_sent++;
		predict_word(x, tmp);
		if (x.action == ACT_FINISH) finishes++;
		if (typed_zero) begin
			// all-zero state: every gradient word is zero
			for (int i = 0; i < tmp.size(); i++)
				grad_q.push_back('{47'd0, 5'(i), 32'sd0, i == tmp.size() - 1});
		end else begin
			foreach (tmp[i]) grad_q.push_back(tmp[i]);
		end
	endtask

	task automatic drain();
		@(negedge clk) start <= 1'b0;
		while (grad_q.size() != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(logic [1:0] r, logic [31:0] d);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= d;
		@(negedge clk) penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_LAMBDA: lam = d;
			REG_MARGIN: marg = d[30:0];
			REG_DIMS: dims = d[5:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [31:0] l, logic [31:0] p, logic [31:0] m);
		drain();
		apb_write(REG_LAMBDA, l);
		apb_write(REG_MARGIN, p);
		apb_write(REG_DIMS, m);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(2) == 0 ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
		endcase
	endfunction

	function automatic in_word_t mk(logic [1:0] a, int idx, logic [31:0] v,
			logic [31:0] t, bit lst);
		in_word_t x;
		x.action = a;
		x.element_index = 5'(idx);
		x.value = v;
		x.target = t;
		x.last_element = lst;
		return x;
	endfunction

	task automatic random_run(int n_items);
		int sent, n, m;
		sent = 0;
		while (sent < n_items) begin
			m = eff_dims();
			case ($urandom_range(9))
				0, 1: begin
					send(mk(ACT_LOAD, $urandom_range(31), rand_val(), $urandom, $urandom_range(1)));
					sent++;
				end
				2: begin
					send(mk(ACT_RSVD, $urandom_range(31), $urandom, $urandom, $urandom_range(1)));
					sent++;
				end
				3: begin
					send(mk(ACT_FINISH, $urandom_range(31), $urandom, $urandom, $urandom_range(1)));
					sent++;
				end
				default: begin
					n = $urandom_range(15) == 0 ? $urandom_range(33, 36) : $urandom_range(1, 6);
					for (int k = 0; k < n; k++) begin
						send(mk(ACT_FEAT,
							$urandom_range(7) == 0 ? $urandom_range(31) : $urandom_range(m - 1),
							rand_val(), $urandom_range(1) ? rand_val() : $urandom,
							k == n - 1 && $urandom_range(9) != 0));
						sent++;
					end
				end
			endcase
		end
		send(mk(ACT_FINISH, 0, 0, 0, 0));
	endtask

	typedef struct {
		in_word_t w;
		bit typed_zero;
	} row_t;

	row_t dir_tab[$];

	initial begin
		reset_model();
		dir_tab = '{
			'{mk(ACT_FINISH, 0, 0, 0, 1), 1},
			'{mk(ACT_LOAD, 0, 32'h7FFFFFFF, 0, 0), 0},
			'{mk(ACT_LOAD, 31, 32'h80000000, 32'hFFFFFFFF, 0), 0},
			'{mk(ACT_LOAD, 5, 32'h00010000, 0, 1), 0},
			'{mk(ACT_RSVD, 31, 32'hFFFFFFFF, 32'hFFFFFFFF, 1), 0},
			'{mk(ACT_FEAT, 0, 32'h7FFFFFFF, 0, 0), 0},
			'{mk(ACT_FEAT, 0, 32'h7FFFFFFF, 0, 0), 0},
			'{mk(ACT_FEAT, 31, 32'h80000000, 32'h80000000, 1), 0},
			'{mk(ACT_FEAT, 5, 32'h00010000, 32'h00010000, 1), 0},
			'{mk(ACT_FEAT, 5, 32'h00020000, 32'h7FFFFFFF, 1), 0},
			'{mk(ACT_FEAT, 3, 32'h00030000, 0, 0), 0},
			'{mk(ACT_FINISH, 0, 0, 0, 1), 0},
			'{mk(ACT_FEAT, 31, 32'h7FFFFFFF, 32'h7FFFFFFF, 1), 0},
			'{mk(ACT_FEAT, 0, 32'h80000000, 32'h80000000, 1), 0},
			'{mk(ACT_FINISH, 0, 0, 0, 0), 0},
			'{mk(ACT_LOAD, 31, 0, 0, 0), 0},
			'{mk(ACT_FINISH, 0, 0, 0, 0), 0}
		};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		foreach (dir_tab[i]) send(dir_tab[i].w, dir_tab[i].typed_zero);

		// register sweep, extremes first
		set_regs(32'hFFFFFFFF, 32'h7FFFFFFF, 1);
		idle_pct = 0;
		random_run(10);
		set_regs(0, 0, 32);
		idle_pct = 58;
		random_run(15);
		set_regs(32'h00008000, 32'h00000001, 0);
		idle_pct = 11;
		random_run(10);
		set_regs(32'h00010000, 32'h00000000, 63);
		idle_pct = 58;
		random_run(15);
		drain();
		set_regs($urandom, $urandom_range(3), $urandom_range(1, 12));
		idle_pct = 0;
		random_run(10);
		set_regs($urandom_range(1 << 18), $urandom & 32'h7FFFFFFF, $urandom_range(63));
		idle_pct = 11;
		random_run(20);

		drain();
		repeat (20) @(posedge clk);
		$display("sent %0d words (%0d finishes), checked %0d gradient words over 7 settings",
			words_sent, finishes, results_seen);
		if (errors == 0 && grad_q.size() == 0) begin
			$display("svr_hinge_loss_gradient regression: pass");
		end else begin
			$display("%0d mismatches, %0d words never seen", errors, grad_q.size());
			$display("svr_hinge_loss_gradient regression: fail");
		end
		$finish;
	end
endmodule
